// ===== hw/rtl/kbc_pkg.sv =====
package kbc_pkg;

  // kind of bus access or device traffic carried by one input beat
  typedef enum logic [1:0] {
    MODE_BUS_READ  = 2'd0,
    MODE_BUS_WRITE = 2'd1,
    MODE_DEVICE    = 2'd2
  } kbc_mode_t;

  localparam logic PORT_DATA   = 1'b0;
  localparam logic PORT_STATUS = 1'b1;

  // controller commands
  localparam logic [7:0] CMD_RAM_READ  = 8'h20;
  localparam logic [7:0] CMD_RAM_WRITE = 8'h60;
  localparam logic [7:0] CMD_SELF_TEST = 8'hAA;
  localparam logic [7:0] CMD_PORT_TEST = 8'hAB;
  localparam logic [7:0] CMD_P1_OFF    = 8'hAD;
  localparam logic [7:0] CMD_P1_ON     = 8'hAE;
  localparam logic [7:0] CMD_P2_OFF    = 8'hA7;

  localparam logic [7:0] SELF_TEST_OK  = 8'h55;

  // controller ram addressing as carried in the command byte
  localparam int RAM_ADDR_W = 5;

  typedef struct packed {
    logic                  en;
    logic [RAM_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } kbc_ram_wr_t;

  typedef struct packed {
    logic       overrun;
    logic       irq;
    logic [7:0] to_device_byte;
    logic       to_device_valid;
    logic [7:0] bus_rd_byte;
  } kbc_result_t;

endpackage

// ===== hw/rtl/kbc_ram.sv =====
module kbc_ram
  import kbc_pkg::*;
#(
  parameter int RAM_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kbc_ram_wr_t           wr,
  input  logic [RAM_ADDR_W-1:0] rd_addr,
  output logic [7:0]            rd_data,
  output logic                  irq_enable
);

  localparam int AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
  localparam logic [RAM_ADDR_W:0] RAM_LIMIT = (RAM_ADDR_W + 1)'(RAM_BYTES);

  logic [7:0] mem [RAM_BYTES];
  logic       wr_in_range;
  logic       rd_in_range;

  assign wr_in_range = {1'b0, wr.addr} < RAM_LIMIT;
  assign rd_in_range = {1'b0, rd_addr} < RAM_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RAM_BYTES; i++) begin
        mem[i] <= '0;
      end
    end else if (wr.en && wr_in_range) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  // bytes beyond the ram read as zero
  assign rd_data    = rd_in_range ? mem[rd_addr[AW-1:0]] : 8'h00;
  assign irq_enable = mem[0][0];

endmodule

// ===== hw/rtl/kbc_core.sv =====
module kbc_core
  import kbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [1:0]            mode,
  input  logic                  port_select,
  input  logic [7:0]            value,
  input  logic [2:0]            port_test_code,
  input  logic [7:0]            ram_rd_data,
  input  logic                  irq_enable,
  output logic [RAM_ADDR_W-1:0] ram_rd_addr,
  output kbc_ram_wr_t           ram_wr,
  output kbc_result_t           result
);

  logic [7:0]            out_buffer, out_buffer_next;
  logic                  out_full, out_full_next;
  logic                  pending_ram_write, pending_ram_write_next;
  logic [RAM_ADDR_W-1:0] pending_ram_index, pending_ram_index_next;
  logic                  first_port_enabled, first_port_enabled_next;
  logic                  second_port_enabled, second_port_enabled_next;
  kbc_mode_t             mode_q;

  assign mode_q      = kbc_mode_t'(mode);
  assign ram_rd_addr = value[RAM_ADDR_W-1:0];

  always_comb begin
    out_buffer_next          = out_buffer;
    out_full_next            = out_full;
    pending_ram_write_next   = pending_ram_write;
    pending_ram_index_next   = pending_ram_index;
    first_port_enabled_next  = first_port_enabled;
    second_port_enabled_next = second_port_enabled;
    ram_wr                   = '0;
    result                   = '0;
    if (go) begin
      unique case (mode_q)
        MODE_BUS_READ: begin
          if (port_select == PORT_STATUS) begin
            result.bus_rd_byte = {7'b0, out_full};
          end else begin
            result.bus_rd_byte = out_buffer;
            out_full_next      = 1'b0;
          end
        end
        MODE_BUS_WRITE: begin
          if (port_select == PORT_STATUS) begin
            // a new command cancels a pending ram write
            pending_ram_write_next = 1'b0;
            priority if (value[7:5] == CMD_RAM_READ[7:5]) begin
              out_buffer_next = ram_rd_data;
              out_full_next   = 1'b1;
            end else if (value[7:5] == CMD_RAM_WRITE[7:5]) begin
              pending_ram_write_next = 1'b1;
              pending_ram_index_next = value[RAM_ADDR_W-1:0];
            end else if (value == CMD_SELF_TEST) begin
              out_buffer_next = SELF_TEST_OK;
              out_full_next   = 1'b1;
            end else if (value == CMD_PORT_TEST) begin
              out_buffer_next = {5'b0, port_test_code};
              out_full_next   = 1'b1;
            end else if (value == CMD_P1_OFF) begin
              first_port_enabled_next = 1'b0;
            end else if (value == CMD_P1_ON) begin
              first_port_enabled_next = 1'b1;
            end else if (value == CMD_P2_OFF) begin
              second_port_enabled_next = 1'b0;
            end else begin
              // unknown command
            end
          end else if (pending_ram_write) begin
            ram_wr.en              = 1'b1;
            ram_wr.addr            = pending_ram_index;
            ram_wr.data            = value;
            pending_ram_write_next = 1'b0;
          end else begin
            result.to_device_valid = 1'b1;
            result.to_device_byte  = value;
          end
        end
        MODE_DEVICE: begin
          if (first_port_enabled && !out_full) begin
            out_buffer_next = value;
            out_full_next   = 1'b1;
            result.irq      = irq_enable;
          end else begin
            result.overrun  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_buffer          <= '0;
      out_full            <= 1'b0;
      pending_ram_write   <= 1'b0;
      pending_ram_index   <= '0;
      first_port_enabled  <= 1'b1;
      second_port_enabled <= 1'b1;
    end else begin
      out_buffer          <= out_buffer_next;
      out_full            <= out_full_next;
      pending_ram_write   <= pending_ram_write_next;
      pending_ram_index   <= pending_ram_index_next;
      first_port_enabled  <= first_port_enabled_next;
      second_port_enabled <= second_port_enabled_next;
    end
  end

  a_device_fills_buffer: assert property (@(posedge clk) disable iff (rst)
    go && mode_q == MODE_DEVICE && first_port_enabled && !out_full |=> out_full)
    else $error("accepted device byte did not fill the output buffer");

  a_data_write_clears_pending: assert property (@(posedge clk) disable iff (rst)
    go && mode_q == MODE_BUS_WRITE && port_select == PORT_DATA |=> !pending_ram_write)
    else $error("ram write still pending after a data write");

  a_port2_stays_off: assert property (@(posedge clk) disable iff (rst)
    !second_port_enabled |=> !second_port_enabled)
    else $error("port 2 came back on without a command");

  a_p1_off: assert property (@(posedge clk) disable iff (rst)
    go && mode_q == MODE_BUS_WRITE && port_select == PORT_STATUS && value == CMD_P1_OFF
    |=> !first_port_enabled)
    else $error("port 1 still enabled after disable command");

endmodule

// ===== hw/rtl/keyboard_controller_8042.sv =====
// Host side of an 8042-style PS/2 keyboard controller. Every slave beat is one
// bus read, one bus write (data port or status/command port) or one byte
// coming in from the attached device, and each beat yields exactly one master
// beat. Beats move through an input register and a result register with the
// decode between them; one beat is taken every cycle unless m_tready stalls
// the results. A finished result may wait on m_tready while the next beat is
// already captured. The controller ram (byte 0 is the configuration byte,
// bit 0 enabling irq) lives in flops cleared by reset, so the block is ready
// right after rst. port_test_code is written through the cfg channel, which
// is always ready; write it only while the block is idle. The status byte
// carries output-full in bit 0, every other bit reads zero.
module keyboard_controller_8042
  import kbc_pkg::*;
#(
  parameter int RAM_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,

  // bus access or device byte in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] value
  input  logic [2:0]  s_tuser,   // [1:0] mode, [2] port_select

  // one result per input beat
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] bus_rd_byte, [8] to_device_valid, [16:9] to_device_byte,
  // [17] irq, [18] overrun, [23:19] zero
  output logic [23:0] m_tdata,

  // port test code register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  // input register
  logic                  in_valid;
  logic [1:0]            in_mode;
  logic                  in_port_select;
  logic [7:0]            in_value;

  // result register
  kbc_result_t           res, res_next;

  logic                  advance;
  logic                  go;
  logic [2:0]            port_test_code;

  logic [RAM_ADDR_W-1:0] ram_rd_addr;
  logic [7:0]            ram_rd_data;
  logic                  irq_enable;
  kbc_ram_wr_t           ram_wr;

  // the stage moves when the result slot is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign go       = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_test_code <= '0;
    end else if (cfg_valid && cfg_ready) begin
      port_test_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode        <= s_tuser[1:0];
      in_port_select <= s_tuser[2];
      in_value       <= s_tdata;
    end
  end

  kbc_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk        (clk),
    .rst        (rst),
    .wr         (ram_wr),
    .rd_addr    (ram_rd_addr),
    .rd_data    (ram_rd_data),
    .irq_enable (irq_enable)
  );

  kbc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .mode           (in_mode),
    .port_select    (in_port_select),
    .value          (in_value),
    .port_test_code (port_test_code),
    .ram_rd_data    (ram_rd_data),
    .irq_enable     (irq_enable),
    .ram_rd_addr    (ram_rd_addr),
    .ram_wr         (ram_wr),
    .result         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= res_next;
    end
  end

  assign m_tdata = {5'b0, res.overrun, res.irq, res.to_device_byte,
                    res.to_device_valid, res.bus_rd_byte};

  a_irq_not_with_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.irq && res.overrun))
    else $error("irq and overrun raised on the same result");

  a_captured_beat_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("captured beat dropped while the result stage was stalled");

endmodule

// ===== tb/keyboard_controller_8042_test.sv =====
`timescale 1ns / 100ps

module keyboard_controller_8042_test;
  import kbc_pkg::*;

  localparam int RAM_BYTES = 32;

  // mode code outside the decoded set, must leave no trace
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // upper three bits select the ram read / ram write command groups
  localparam logic [7:0] CMD_GROUP_MASK = 8'hE0;
  localparam logic [7:0] CMD_UNKNOWN = 8'h00;

  localparam int CHUNK_BEATS = 248;
  localparam int CHUNKS = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX = 10;

  // one slave beat as the host or the device presents it
  typedef struct packed {
    logic [1:0] mode;
    logic       port;
    logic [7:0] value;
  } kbc_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] value
  logic [2:0]  s_tuser = '0;    // [1:0] mode, [2] port_select
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] bus_rd_byte, [8] to_device_valid,
                                // [16:9] to_device_byte, [17] irq, [18] overrun
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;

  // controller state as the host should see it
  logic [7:0] buf_byte = 8'h00;
  logic       buf_full = 1'b0;
  logic [7:0] ram_copy [RAM_BYTES] = '{default: 8'h00};
  logic       ram_wr_armed = 1'b0;
  logic [4:0] ram_wr_index = '0;
  logic       port1_on = 1'b1;
  logic       port2_on = 1'b1;
  logic [2:0] test_code = '0;

  kbc_beat_t   bus_beat_q [$];
  kbc_result_t expected_result_q [$];

  logic beat_taken = 1'b0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   chunk_beats = 0;

  int cycle_count = 0;
  int mismatch_count = 0;
  int accepted_beats = 0;
  int checked_results = 0;
  int device_taken = 0;
  int device_dropped = 0;
  int irq_count = 0;
  int cfg_writes = 0;

  keyboard_controller_8042 #(
    .RAM_BYTES(RAM_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // host-visible response to one beat; updates the tracked controller state
  function automatic kbc_result_t controller_response(input kbc_beat_t b);
    kbc_result_t r;
    logic [7:0] cmd;
    r = '0;
    cmd = b.value;
    case (b.mode)
      MODE_BUS_READ: begin
        if (b.port == PORT_STATUS) begin
          // only output-full is reported, input-full always reads zero
          r.bus_rd_byte = {7'd0, buf_full};
        end else begin
          // stale byte comes back even when the buffer is empty
          r.bus_rd_byte = buf_byte;
          buf_full = 1'b0;
        end
      end
      MODE_BUS_WRITE: begin
        if (b.port == PORT_STATUS) begin
          // any command drops a ram write still waiting for its data
          ram_wr_armed = 1'b0;
          if ((cmd & CMD_GROUP_MASK) == CMD_RAM_READ) begin
            buf_byte = (cmd[4:0] < RAM_BYTES) ? ram_copy[cmd[4:0]] : 8'h00;
            buf_full = 1'b1;
          end else if ((cmd & CMD_GROUP_MASK) == CMD_RAM_WRITE) begin
            ram_wr_armed = 1'b1;
            ram_wr_index = cmd[4:0];
          end else if (cmd == CMD_SELF_TEST) begin
            buf_byte = SELF_TEST_OK;
            buf_full = 1'b1;
          end else if (cmd == CMD_PORT_TEST) begin
            buf_byte = {5'd0, test_code};
            buf_full = 1'b1;
          end else if (cmd == CMD_P1_OFF) begin
            port1_on = 1'b0;
          end else if (cmd == CMD_P1_ON) begin
            port1_on = 1'b1;
          end else if (cmd == CMD_P2_OFF) begin
            port2_on = 1'b0;
          end
        end else if (ram_wr_armed) begin
          if (ram_wr_index < RAM_BYTES) ram_copy[ram_wr_index] = b.value;
          ram_wr_armed = 1'b0;
        end else begin
          r.to_device_valid = 1'b1;
          r.to_device_byte = b.value;
        end
      end
      MODE_DEVICE: begin
        if (port1_on && !buf_full) begin
          buf_byte = b.value;
          buf_full = 1'b1;
          r.irq = ram_copy[0][0];
          device_taken++;
          if (r.irq) irq_count++;
        end else begin
          r.overrun = 1'b1;
          device_dropped++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: present the head of the queue, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beat_taken) begin
      if (bus_beat_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= bus_beat_q[0].value;
        s_tuser <= {bus_beat_q[0].port, bus_beat_q[0].mode};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // accepted input beats feed the prediction, result beats are checked
  always @(posedge clk) begin : sample
    kbc_result_t got_result;
    kbc_result_t want_result;
    beat_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_result_q.push_back(controller_response(bus_beat_q.pop_front()));
      accepted_beats++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got_result = m_tdata[18:0];
      if (expected_result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result beat with nothing expected: %06h", $realtime, m_tdata);
      end else begin
        want_result = expected_result_q.pop_front();
        checked_results++;
        if (got_result.bus_rd_byte !== want_result.bus_rd_byte ||
            got_result.to_device_valid !== want_result.to_device_valid ||
            got_result.to_device_byte !== want_result.to_device_byte ||
            got_result.irq !== want_result.irq ||
            got_result.overrun !== want_result.overrun) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: result %0d exp rd=%02h dv=%b db=%02h irq=%b ovr=%b",
                     $realtime, checked_results, want_result.bus_rd_byte,
                     want_result.to_device_valid, want_result.to_device_byte,
                     want_result.irq, want_result.overrun,
                     " got rd=%02h dv=%b db=%02h irq=%b ovr=%b",
                     got_result.bus_rd_byte, got_result.to_device_valid,
                     got_result.to_device_byte, got_result.irq, got_result.overrun);
        end
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL keyboard_controller_8042");
      $finish;
    end
  end

  task automatic add_beat(input logic [1:0] mode, input logic port, input logic [7:0] value);
    kbc_beat_t b;
    b.mode = mode;
    b.port = port;
    b.value = value;
    bus_beat_q.push_back(b);
    if (mode != MODE_UNUSED) chunk_beats++;
  endtask

  // mostly well-formed host sequences with random content, some noise
  task automatic add_random_burst();
    int kind;
    int n;
    logic [4:0] idx;
    kind = $urandom_range(0, 11);
    n = $urandom_range(1, 3);
    // lean on ram byte 0 so the irq enable keeps flipping
    idx = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, RAM_BYTES - 1));
    case (kind)
      0: begin
        add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_RAM_WRITE | idx);
        add_beat(MODE_BUS_WRITE, PORT_DATA, 8'($urandom));
      end
      1: begin
        add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_RAM_READ | idx);
        add_beat(MODE_BUS_READ, PORT_STATUS, 8'($urandom));
        add_beat(MODE_BUS_READ, PORT_DATA, 8'($urandom));
      end
      2: begin
        add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_SELF_TEST);
        add_beat(MODE_BUS_READ, PORT_DATA, 8'($urandom));
      end
      3: begin
        add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_PORT_TEST);
        add_beat(MODE_BUS_READ, PORT_DATA, 8'($urandom));
      end
      4, 5, 6: begin
        // device bytes, sometimes left unread so later ones overrun
        repeat (n) add_beat(MODE_DEVICE, 1'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) != 0) begin
          add_beat(MODE_BUS_READ, PORT_STATUS, 8'($urandom));
          add_beat(MODE_BUS_READ, PORT_DATA, 8'($urandom));
        end
      end
      7: add_beat(MODE_BUS_WRITE, PORT_DATA, 8'($urandom));
      8: begin
        add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_P1_OFF);
        add_beat(MODE_DEVICE, 1'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) != 0) add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_P1_ON);
      end
      9: begin
        // ram write cut short by another command
        add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_RAM_WRITE | idx);
        add_beat(MODE_BUS_WRITE, PORT_STATUS,
                 ($urandom_range(0, 1) != 0) ? CMD_P2_OFF : 8'($urandom));
        add_beat(MODE_BUS_WRITE, PORT_DATA, 8'($urandom));
      end
      10: repeat (n) add_beat(2'($urandom), 1'($urandom), 8'($urandom));
      default: add_beat(MODE_BUS_READ, 1'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic wait_idle();
    while (bus_beat_q.size() != 0 || s_tvalid || expected_result_q.size() != 0)
      @(negedge clk);
    // two-stage pipeline, let it settle before the next step
    repeat (4) @(negedge clk);
  endtask

  task automatic write_test_code(input logic [2:0] code);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    test_code = code;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 14;
    snk_idle_pct = 68;

    // directed: empty reads, port test at reset code, overwrite while full
    add_beat(MODE_BUS_READ, PORT_STATUS, 8'hFF);
    add_beat(MODE_BUS_READ, PORT_DATA, 8'h00);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_PORT_TEST);
    add_beat(MODE_BUS_READ, PORT_DATA, 8'h00);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_SELF_TEST);
    add_beat(MODE_BUS_READ, PORT_STATUS, 8'h00);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_RAM_READ | 8'h1F);
    add_beat(MODE_BUS_READ, PORT_DATA, 8'h00);
    // pass-through to the device, then irq enable through ram byte 0
    add_beat(MODE_BUS_WRITE, PORT_DATA, 8'hFF);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_RAM_WRITE);
    add_beat(MODE_BUS_WRITE, PORT_DATA, 8'h01);
    add_beat(MODE_DEVICE, PORT_DATA, 8'hFF);
    add_beat(MODE_DEVICE, PORT_STATUS, 8'h00);
    add_beat(MODE_BUS_READ, PORT_DATA, 8'h00);
    // port 1 off drops device bytes
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_P1_OFF);
    add_beat(MODE_DEVICE, PORT_DATA, 8'h5A);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_P1_ON);
    // pending ram write cancelled by a command, data then goes out
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_RAM_WRITE | 8'h1F);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_P2_OFF);
    add_beat(MODE_BUS_WRITE, PORT_DATA, 8'h3C);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_UNKNOWN);
    add_beat(MODE_UNUSED, PORT_STATUS, 8'hFF);
    // device byte with irq on, then with irq off
    add_beat(MODE_DEVICE, PORT_DATA, 8'hA5);
    add_beat(MODE_BUS_READ, PORT_DATA, 8'h00);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_RAM_WRITE);
    add_beat(MODE_BUS_WRITE, PORT_DATA, 8'hFE);
    add_beat(MODE_DEVICE, PORT_DATA, 8'h81);
    wait_idle();

    // port test answer with codes 4 and 7, 7 being the top of the 3-bit range
    write_test_code(3'd4);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_PORT_TEST);
    add_beat(MODE_BUS_READ, PORT_DATA, 8'h00);
    wait_idle();
    write_test_code(3'd7);
    add_beat(MODE_BUS_WRITE, PORT_STATUS, CMD_PORT_TEST);
    add_beat(MODE_BUS_READ, PORT_DATA, 8'h00);
    wait_idle();

    // random chunks: two per idle pattern, new port test code each time
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk / 2)
        0: begin
          src_idle_pct = 14;
          snk_idle_pct = 68;
        end
        1: begin
          src_idle_pct = 68;
          snk_idle_pct = 14;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      write_test_code(chunk == 0 ? 3'd0 : chunk == 3 ? 3'd4 : 3'($urandom_range(0, 7)));
      chunk_beats = 0;
      while (chunk_beats < CHUNK_BEATS) add_random_burst();
      wait_idle();
    end

    $display("covered %0d beats, %0d results checked: %0d device bytes taken, %0d dropped, %0d irq",
             accepted_beats, checked_results, device_taken, device_dropped, irq_count);
    $display("%0d port test code writes over three idle patterns", cfg_writes);
    if (mismatch_count == 0 && expected_result_q.size() == 0) begin
      $display("PASS keyboard_controller_8042");
    end else begin
      $display("FAIL keyboard_controller_8042");
    end
    $finish;
  end

endmodule
